/* hw/rtl/memory_range_attribute_table_top_macros.svh */
// Assertion macros for the memory range attribute table.
// Used by the top level; needs a signal named clock and one named reset in scope.
`ifndef MEMORY_RANGE_ATTRIBUTE_TABLE_TOP_MACROS_SVH
`define MEMORY_RANGE_ATTRIBUTE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define MRAT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MRAT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/mrat_pkg.sv */
// Shared types, constants and decode functions for the range attribute table.
// No dependencies.
`timescale 1ns / 1ps

package mrat_pkg;

   localparam int FIXED_64K_COUNT = 8;
   localparam int FIXED_16K_COUNT = 16;
   localparam int FIXED_4K_COUNT  = 64;
   localparam int FIX_TOTAL       = FIXED_64K_COUNT + FIXED_16K_COUNT + FIXED_4K_COUNT;
   localparam int VAR_MAX_DEF     = 8;

   localparam logic [2:0] MT_UC = 3'd0;
   localparam logic [2:0] MT_WC = 3'd1;
   localparam logic [2:0] MT_WT = 3'd4;
   localparam logic [2:0] MT_WP = 3'd5;
   localparam logic [2:0] MT_WB = 3'd6;
   localparam logic [2:0] MT_RESERVED = 3'd7;
   localparam logic [2:0] MT_UNKNOWN_CLASS = 3'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FIXED_ENABLE = 2'd0;
   localparam logic [1:0] CSR_VAR_COUNT    = 2'd1;
   localparam logic [1:0] CSR_PA_BITS      = 2'd2;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_INVAL = 3'd1,
      ST_ACCES = 3'd2,
      ST_NOSPC = 3'd3,
      ST_NOENT = 3'd4,
      ST_PERM  = 3'd5
   } status_type;

   function automatic logic type_known(input logic [2:0] t);
      return (t == MT_UC) || (t == MT_WC) || (t == MT_WT) || (t == MT_WP) || (t == MT_WB);
   endfunction

   function automatic logic types_conflict(input logic [2:0] a, input logic [2:0] b);
      logic [2:0] ca;
      logic [2:0] cb;
      ca = type_known(a) ? a : MT_UNKNOWN_CLASS;
      cb = type_known(b) ? b : MT_UNKNOWN_CLASS;
      return !((ca == cb) || (ca == MT_WB && cb == MT_UC) || (ca == MT_UC && cb == MT_WB));
   endfunction

   // fixed entry covering an address below 1 MiB
   function automatic logic [6:0] fixed_index(input logic [19:0] a);
      if (a < 20'h80000)
         return {3'b000, a[19:16]};
      else if (a < 20'hc0000)
         return 7'(FIXED_64K_COUNT) + {3'b000, a[17:14]};
      else
         return 7'(FIXED_64K_COUNT + FIXED_16K_COUNT) + {1'b0, a[17:12]};
   endfunction

   function automatic logic [19:0] fixed_len_at(input logic [19:0] a);
      if (a < 20'h80000)
         return 20'h10000;
      else if (a < 20'hc0000)
         return 20'h04000;
      else
         return 20'h01000;
   endfunction

endpackage

/* hw/rtl/mrat_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mrat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/memory_range_attribute_table_top.sv */
// Top level of the memory range attribute table: sequencer, config and result register.
// Depends on mrat_pkg, mrat_ram and the macros header.
//
//  channel | direction | handshake      | payload
//  req     | in        | valid / stall  | action, base, length, mem_type, force_req
//  rsp     | out       | valid / stall  | status, entry
//  csr     | in        | valid / ready  | index, data
//
// One request at a time: accept in idle, decide, then result hand-off.
// Fixed update: each covered entry is read and type-checked (skipped when forced),
// then each entry is written. Variable scan: each entry is read, then checked (one RAM
// read port), followed by an end check. A success adds the read-back sweep: an inactive
// entry is rewritten to its default range, an active one is read and written back
// masked to the address width, followed by an end check.
// Reset state comes from valid bits in flops; no clearing pass. Result register lets
// the next word enter while a result waits under rsp_stall.
`timescale 1ns / 1ps
`include "memory_range_attribute_table_top_macros.svh"

module memory_range_attribute_table_top #(
   parameter int VAR_MAX = mrat_pkg::VAR_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [51:0] req_base,
   input  logic [52:0] req_length,
   input  logic [2:0]  req_mem_type,
   input  logic        req_force_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_entry,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);

   localparam int VAW = (VAR_MAX > 1) ? $clog2(VAR_MAX) : 1;
   localparam int CW  = $clog2(VAR_MAX + 1);
   localparam int NW  = CW + 4;
   localparam int VW  = 3 + 53 + 52;
   localparam int FAW = $clog2(mrat_pkg::FIX_TOTAL);

   localparam logic [52:0] RESET_LEN = 53'h1 << 36;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_DECIDE = 11'b00000000010,
      S_FX_RD  = 11'b00000000100,
      S_FX_CHK = 11'b00000001000,
      S_FX_WR  = 11'b00000010000,
      S_VR_RD  = 11'b00000100000,
      S_VR_CHK = 11'b00001000000,
      S_VWRITE = 11'b00010000000,
      S_RB_RD  = 11'b00100000000,
      S_RB_WR  = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic        fixed_enable_ff;
   logic [3:0]  var_count_ff;
   logic [5:0]  pa_bits_ff;

   logic        act_ff, force_ff;
   logic [51:0] base_ff;
   logic [52:0] len_ff;
   logic [2:0]  typ_ff;

   logic [6:0]  k_ff, k_in, last_ff, last_in, first_ff, first_in;
   logic [CW-1:0] vidx_ff, vidx_in, free_ff, free_in;
   logic        free_found_ff, free_found_in;
   logic [6:0]  ent_ff, ent_in;
   mrat_pkg::status_type st_ff, st_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_entry_ff, rsp_entry_in;

   logic [mrat_pkg::FIX_TOTAL-1:0] fx_vld_ff;
   logic [VAR_MAX-1:0] vr_vld_ff, vr_act_ff, vr_act_in;
   logic        fx_rvld_ff, vr_rvld_ff;

   logic           fx_re, fx_we;
   logic [2:0]     fx_q;
   logic           vr_re, vr_we;
   logic [VAW-1:0] vr_waddr;
   logic [VW-1:0]  vr_wdata, vr_q;

   logic [NW-1:0] n_used;
   logic [5:0]    pa_eff;
   logic [51:0]   pa_mask;
   logic [6:0]    var_off;

   logic [52:0] len_m1;
   logic [53:0] end_sum;
   logic        bad_req, in_fixed, perm_hit;
   logic [19:0] last_a, fl;

   logic [VW-1:0] vrd;
   logic [51:0]   vb;
   logic [52:0]   vl, vl_m1;
   logic [2:0]    vt;
   logic          vmatch, vover;
   logic [2:0]    fx_type;
   logic          at_end;

   always_comb begin
      n_used = ({{CW{1'b0}}, var_count_ff} < NW'(VAR_MAX)) ?
               {{CW{1'b0}}, var_count_ff} : NW'(VAR_MAX);
      pa_eff = (pa_bits_ff < 6'd36) ? 6'd36 : ((pa_bits_ff > 6'd52) ? 6'd52 : pa_bits_ff);
      for (int j = 0; j < 52; j++) begin
         pa_mask[j] = (j >= 12) && (6'(j) < pa_eff);
      end
      var_off = fixed_enable_ff ? 7'(mrat_pkg::FIX_TOTAL) : 7'd0;
      at_end  = ({4'b0000, vidx_ff} == n_used);
   end

   // request decode on the latched word
   always_comb begin
      len_m1   = len_ff - 53'd1;
      end_sum  = {2'b00, base_ff} + {1'b0, len_ff};
      bad_req  = (base_ff[11:0] != 12'd0) || (len_ff < 53'h1000) ||
                 ((len_ff & len_m1) != 53'd0) || ((base_ff & len_m1[51:0]) != 52'd0) ||
                 !mrat_pkg::type_known(typ_ff);
      in_fixed = fixed_enable_ff && (end_sum <= 54'h100000);
      last_a   = base_ff[19:0] + len_m1[19:0];
      fl       = mrat_pkg::fixed_len_at(base_ff[19:0]);
      perm_hit = fixed_enable_ff && (base_ff < 52'h100000) && (len_ff == 53'(fl)) &&
                 ((base_ff[19:0] & (fl - 20'd1)) == 20'd0);
   end

   // variable entry as read back, reset value when never written
   always_comb begin
      vrd    = vr_rvld_ff ? vr_q : {3'd0, RESET_LEN, 52'd0};
      vb     = vrd[51:0];
      vl     = vrd[104:52];
      vt     = vrd[107:105];
      vl_m1  = vl - 53'd1;
      vmatch = (vb == base_ff) && (vl == len_ff);
      vover  = ((base_ff >= vb) && ({2'b00, base_ff} < ({2'b00, vb} + {1'b0, vl}))) ||
               ((vb >= base_ff) && ({2'b00, vb} < end_sum));
      fx_type = fx_rvld_ff ? fx_q : mrat_pkg::MT_UC;
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      last_in       = last_ff;
      first_in      = first_ff;
      vidx_in       = vidx_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      ent_in        = ent_ff;
      st_in         = st_ff;
      vr_act_in     = vr_act_ff;
      fx_re         = 1'b0;
      fx_we         = 1'b0;
      vr_re         = 1'b0;
      vr_we         = 1'b0;
      vr_waddr      = vidx_ff[VAW-1:0];
      vr_wdata      = {typ_ff, len_ff, base_ff};
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            vidx_in       = '0;
            free_found_in = 1'b0;
            ent_in        = 7'd0;
            if (act_ff) begin
               if (perm_hit) begin
                  st_in    = mrat_pkg::ST_PERM;
                  state_in = S_DONE;
               end else begin
                  state_in = S_VR_RD;
               end
            end else if (bad_req) begin
               st_in    = mrat_pkg::ST_INVAL;
               state_in = S_DONE;
            end else if (in_fixed) begin
               first_in = mrat_pkg::fixed_index(base_ff[19:0]);
               k_in     = mrat_pkg::fixed_index(base_ff[19:0]);
               last_in  = mrat_pkg::fixed_index(last_a);
               state_in = force_ff ? S_FX_WR : S_FX_RD;
            end else begin
               state_in = S_VR_RD;
            end
         end
         S_FX_RD: begin
            fx_re    = 1'b1;
            state_in = S_FX_CHK;
         end
         S_FX_CHK: begin
            if (!mrat_pkg::type_known(fx_type)) begin
               st_in    = mrat_pkg::ST_ACCES;
               state_in = S_DONE;
            end else if (k_ff == last_ff) begin
               k_in     = first_ff;
               state_in = S_FX_WR;
            end else begin
               k_in     = k_ff + 7'd1;
               state_in = S_FX_RD;
            end
         end
         S_FX_WR: begin
            fx_we = 1'b1;
            k_in  = k_ff + 7'd1;
            if (k_ff == last_ff) begin
               st_in    = mrat_pkg::ST_OK;
               ent_in   = first_ff;
               vidx_in  = '0;
               state_in = S_RB_RD;
            end
         end
         S_VR_RD: begin
            if (at_end) begin
               if (act_ff) begin
                  st_in    = mrat_pkg::ST_NOENT;
                  state_in = S_DONE;
               end else if (free_found_ff) begin
                  state_in = S_VWRITE;
               end else begin
                  st_in    = mrat_pkg::ST_NOSPC;
                  state_in = S_DONE;
               end
            end else begin
               vr_re    = 1'b1;
               state_in = S_VR_CHK;
            end
         end
         S_VR_CHK: begin
            vidx_in  = vidx_ff + 1'b1;
            state_in = S_VR_RD;
            if (act_ff) begin
               if (vmatch) begin
                  vr_act_in[vidx_ff[VAW-1:0]] = 1'b0;
                  st_in    = mrat_pkg::ST_OK;
                  ent_in   = var_off + 7'(vidx_ff);
                  vidx_in  = '0;
                  state_in = S_RB_RD;
               end
            end else if (vr_act_ff[vidx_ff[VAW-1:0]]) begin
               if (vmatch) begin
                  if (!force_ff && !mrat_pkg::type_known(vt)) begin
                     st_in    = mrat_pkg::ST_ACCES;
                     state_in = S_DONE;
                  end else begin
                     free_in       = vidx_ff;
                     free_found_in = 1'b1;
                     state_in      = S_VWRITE;
                  end
               end else if (vover && mrat_pkg::types_conflict(vt, typ_ff)) begin
                  st_in    = mrat_pkg::ST_INVAL;
                  state_in = S_DONE;
               end
            end else if (!free_found_ff) begin
               free_in       = vidx_ff;
               free_found_in = 1'b1;
            end
         end
         S_VWRITE: begin
            vr_we    = 1'b1;
            vr_waddr = free_ff[VAW-1:0];
            vr_act_in[free_ff[VAW-1:0]] = 1'b1;
            st_in    = mrat_pkg::ST_OK;
            ent_in   = var_off + 7'(free_ff);
            vidx_in  = '0;
            state_in = S_RB_RD;
         end
         S_RB_RD: begin
            if (at_end) begin
               state_in = S_DONE;
            end else if (!vr_act_ff[vidx_ff[VAW-1:0]]) begin
               vr_we    = 1'b1;
               vr_wdata = {3'd0, 53'h1 << pa_eff, 52'd0};
               vidx_in  = vidx_ff + 1'b1;
            end else begin
               vr_re    = 1'b1;
               state_in = S_RB_WR;
            end
         end
         S_RB_WR: begin
            vr_we    = 1'b1;
            vr_wdata = {vt, (((vl_m1 & {1'b0, pa_mask}) | 53'hfff) + 53'd1), vb & pa_mask};
            vidx_in  = vidx_ff + 1'b1;
            state_in = S_RB_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_entry_in  = (st_ff == mrat_pkg::ST_OK) ? ent_ff : 7'd0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         fixed_enable_ff <= 1'b1;
         var_count_ff    <= 4'd8;
         pa_bits_ff      <= 6'd36;
         fx_vld_ff       <= '0;
         vr_vld_ff       <= '0;
         vr_act_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         vr_act_ff    <= vr_act_in;
         if (fx_we) begin
            fx_vld_ff[k_ff[FAW-1:0]] <= 1'b1;
         end
         if (vr_we) begin
            vr_vld_ff[vr_waddr] <= 1'b1;
         end
         if (csr_valid) begin
            unique case (csr_index)
               mrat_pkg::CSR_FIXED_ENABLE: fixed_enable_ff <= csr_data[0];
               mrat_pkg::CSR_VAR_COUNT:    var_count_ff    <= csr_data[3:0];
               mrat_pkg::CSR_PA_BITS:      pa_bits_ff      <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         act_ff   <= req_action;
         base_ff  <= req_base;
         len_ff   <= req_length;
         typ_ff   <= req_mem_type;
         force_ff <= req_force_req;
      end
      k_ff          <= k_in;
      last_ff       <= last_in;
      first_ff      <= first_in;
      vidx_ff       <= vidx_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      ent_ff        <= ent_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      if (fx_re) begin
         fx_rvld_ff <= fx_vld_ff[k_ff[FAW-1:0]];
      end
      if (vr_re) begin
         vr_rvld_ff <= vr_vld_ff[vidx_ff[VAW-1:0]];
      end
   end

   mrat_ram #(
      .WIDTH(3),
      .DEPTH(mrat_pkg::FIX_TOTAL)
   ) u_fixed_ram (
      .clock(clock),
      .we   (fx_we),
      .waddr(k_ff[FAW-1:0]),
      .wdata(typ_ff),
      .re   (fx_re),
      .raddr(k_ff[FAW-1:0]),
      .rdata(fx_q)
   );

   mrat_ram #(
      .WIDTH(VW),
      .DEPTH(VAR_MAX)
   ) u_var_ram (
      .clock(clock),
      .we   (vr_we),
      .waddr(vr_waddr),
      .wdata(vr_wdata),
      .re   (vr_re),
      .raddr(vidx_ff[VAW-1:0]),
      .rdata(vr_q)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;

   `MRAT_ASSERT_NOW(a_err_entry_zero, rsp_valid_ff && (rsp_status_ff != mrat_pkg::ST_OK), rsp_entry_ff == 7'd0)
   `MRAT_ASSERT_NOW(a_fixed_wr_enabled, fx_we, fixed_enable_ff && (k_ff <= last_ff))
   `MRAT_ASSERT_NOW(a_var_wr_in_use, vr_we, {4'b0000, vidx_ff} < n_used || state_ff == S_VWRITE)
   `MRAT_ASSERT_NEXT(a_accept_decode, req_valid && !req_stall, state_ff == S_DECIDE)
   `MRAT_ASSERT_NOW(a_one_mem_op, vr_we && vr_re, 1'b0)

endmodule

/* sim/tb_memory_range_attribute_table_top.sv */
// Testbench for the memory range attribute table: random and directed range
// requests checked against a behavioral predictor. Depends on mrat_pkg and the top level.
`timescale 1ns / 1ps

module tb_memory_range_attribute_table_top;

   localparam int NVAR = 8;
   localparam int LIMIT = 20000;

   typedef struct {
      logic        action;
      logic [51:0] base;
      logic [52:0] length;
      logic [2:0]  mem_type;
      logic        force_req;
   } req_word_type;

   typedef struct {
      mrat_pkg::status_type status;
      logic [6:0] entry;
   } rsp_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_action = 0, req_force_req = 0;
   logic [51:0] req_base = 0;
   logic [52:0] req_length = 0;
   logic [2:0] req_mem_type = 0;
   logic rsp_stall = 0;
   logic csr_valid = 0;
   logic [1:0] csr_index = 0;
   logic [5:0] csr_data = 0;
   logic req_stall, rsp_valid, csr_ready;
   logic [2:0] rsp_status;
   logic [6:0] rsp_entry;

   memory_range_attribute_table_top dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic        cfg_fixed;
   logic [3:0]  cfg_count;
   logic [5:0]  cfg_pa;
   logic [2:0]  fix_type [mrat_pkg::FIX_TOTAL];
   logic [63:0] vbase [NVAR];
   logic [63:0] vlen [NVAR];
   logic [2:0]  vtype [NVAR];
   logic        vact [NVAR];

   req_word_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   int errors = 0;
   int idle_cycles = 0;

   function automatic bit known_mt(logic [2:0] t);
      return t == mrat_pkg::MT_UC || t == mrat_pkg::MT_WC || t == mrat_pkg::MT_WT ||
             t == mrat_pkg::MT_WP || t == mrat_pkg::MT_WB;
   endfunction

   function automatic bit clash(logic [2:0] a, logic [2:0] b);
      logic [2:0] ca, cb;
      ca = known_mt(a) ? a : mrat_pkg::MT_UNKNOWN_CLASS;
      cb = known_mt(b) ? b : mrat_pkg::MT_UNKNOWN_CLASS;
      return !(ca == cb || (ca == mrat_pkg::MT_WB && cb == mrat_pkg::MT_UC) ||
               (ca == mrat_pkg::MT_UC && cb == mrat_pkg::MT_WB));
   endfunction

   function automatic int fix_slot(logic [63:0] a);
      if (a < 64'h80000) return int'(a >> 16);
      if (a < 64'hc0000) return 8 + int'((a - 64'h80000) >> 14);
      return 24 + int'((a - 64'hc0000) >> 12);
   endfunction

   function automatic logic [63:0] fix_size(logic [63:0] a);
      if (a < 64'h80000) return 64'h10000;
      if (a < 64'hc0000) return 64'h4000;
      return 64'h1000;
   endfunction

   function automatic int pa_eff();
      return cfg_pa < 36 ? 36 : (cfg_pa > 52 ? 52 : int'(cfg_pa));
   endfunction

   function automatic int var_used();
      return cfg_count < NVAR ? int'(cfg_count) : NVAR;
   endfunction

   function automatic bit covers(logic [63:0] b, logic [63:0] l, logic [63:0] a);
      return a >= b && a < b + l;
   endfunction

   task automatic predict_range(input req_word_type r);
      logic [63:0] b, l, mask;
      int off, n, fr, first, last, pa;
      mrat_pkg::status_type st;
      int ent;
      b = {12'd0, r.base};
      l = {11'd0, r.length};
      off = cfg_fixed ? mrat_pkg::FIX_TOTAL : 0;
      n = var_used();
      fr = -1;
      ent = 0;
      st = mrat_pkg::ST_OK;
      if (!r.action) begin
         if (b[11:0] != 0 || l < 64'h1000 || (l & (l - 1)) != 0 || (b & (l - 1)) != 0
               || !known_mt(r.mem_type)) begin
            st = mrat_pkg::ST_INVAL;
         end else if (cfg_fixed && b + l <= 64'h100000) begin
            first = fix_slot(b);
            last = fix_slot(b + l - 1);
            if (!r.force_req)
               for (int k = first; k <= last; k++)
                  if (!known_mt(fix_type[k])) st = mrat_pkg::ST_ACCES;
            if (st == mrat_pkg::ST_OK) begin
               for (int k = first; k <= last; k++) fix_type[k] = r.mem_type;
               ent = first;
            end
         end else begin
            for (int i = 0; i < n; i++) begin
               if (st != mrat_pkg::ST_OK) break;
               if (vact[i]) begin
                  if (vbase[i] == b && vlen[i] == l) begin
                     if (!r.force_req && !known_mt(vtype[i])) st = mrat_pkg::ST_ACCES;
                     fr = i;
                     break;
                  end
                  if ((covers(vbase[i], vlen[i], b) || covers(b, l, vbase[i]))
                        && clash(vtype[i], r.mem_type)) st = mrat_pkg::ST_INVAL;
               end else if (fr < 0) begin
                  fr = i;
               end
            end
            if (st == mrat_pkg::ST_OK && fr < 0) st = mrat_pkg::ST_NOSPC;
            if (st == mrat_pkg::ST_OK) begin
               vbase[fr] = b; vlen[fr] = l; vtype[fr] = r.mem_type; vact[fr] = 1;
               ent = off + fr;
            end
         end
      end else begin
         st = mrat_pkg::ST_NOENT;
         if (cfg_fixed && b < 64'h100000 && l == fix_size(b) && (b & (fix_size(b) - 1)) == 0)
            st = mrat_pkg::ST_PERM;
         else
            for (int i = 0; i < n; i++)
               if (vbase[i] == b && vlen[i] == l) begin
                  vact[i] = 0;
                  ent = off + i;
                  st = mrat_pkg::ST_OK;
                  break;
               end
      end
      if (st == mrat_pkg::ST_OK) begin
         pa = pa_eff();
         mask = ((64'd1 << pa) - 1) & ~64'hfff;
         for (int i = 0; i < n; i++)
            if (!vact[i]) begin
               vbase[i] = 0; vlen[i] = 64'd1 << pa; vtype[i] = mrat_pkg::MT_UC;
            end else begin
               vbase[i] &= mask;
               vlen[i] = (((vlen[i] - 1) & mask) | 64'hfff) + 1;
            end
      end else begin
         ent = 0;
      end
      expected_rsps.push_back('{st, 7'(ent)});
   endtask

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) req_gap = 0;
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0 || pending_reqs.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_valid <= 0;
            end else begin
               req_word_type r;
               r = pending_reqs.pop_front();
               predict_range(r);
               req_valid <= 1;
               req_action <= r.action; req_base <= r.base; req_length <= r.length;
               req_mem_type <= r.mem_type; req_force_req <= r.force_req;
            end
         end
      end
   end

   // monitor and output stall
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result status=%0d entry=%0d", rsp_status, rsp_entry);
               errors++;
            end else begin
               rsp_word_type e;
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_entry !== e.entry) begin
                  $error("entry expected %0d actual %0d", e.entry, rsp_entry);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
               || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT) begin
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
      @(posedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         mrat_pkg::CSR_FIXED_ENABLE: cfg_fixed = val[0];
         mrat_pkg::CSR_VAR_COUNT:    cfg_count = val[3:0];
         mrat_pkg::CSR_PA_BITS:      cfg_pa = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   function automatic req_word_type mk(logic a, logic [63:0] b, logic [63:0] l,
                                       logic [2:0] t, logic f);
      req_word_type r;
      r.action = a; r.base = b[51:0]; r.length = l[52:0]; r.mem_type = t; r.force_req = f;
      return r;
   endfunction

   // mostly well-formed power-of-two ranges, some noise
   function automatic req_word_type rand_req();
      logic [63:0] b, l;
      int sh;
      logic [2:0] t;
      t = ($urandom_range(0, 7) == 0) ? 3'($urandom) :
          ($urandom_range(0, 1) ? mrat_pkg::MT_UC : mrat_pkg::MT_WB);
      if ($urandom_range(0, 2) == 0) t = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0: return mk(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                      3'($urandom), 1'($urandom));
         1, 2, 3: begin
            sh = $urandom_range(12, 19);
            b = 64'($urandom_range(0, 255)) << 12 & ~((64'd1 << sh) - 1);
            l = 64'd1 << sh;
         end
         default: begin
            sh = $urandom_range(12, 52);
            b = (64'($urandom_range(0, 7)) << sh) & 64'h000f_ffff_ffff_ffff;
            if ($urandom_range(0, 1)) b = 64'($urandom_range(0, 7)) << 20 & ~((64'd1 << sh) - 1);
            l = 64'd1 << sh;
         end
      endcase
      return mk($urandom_range(0, 3) == 0, b, l, t, $urandom_range(0, 3) == 0);
   endfunction

   initial begin
      cfg_fixed = 1; cfg_count = 8; cfg_pa = 36;
      foreach (fix_type[i]) fix_type[i] = mrat_pkg::MT_UC;
      for (int i = 0; i < NVAR; i++) begin
         vbase[i] = 0; vlen[i] = 64'd1 << 36; vtype[i] = mrat_pkg::MT_UC; vact[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed
      pending_reqs.push_back(mk(0, 0, 64'h1000, mrat_pkg::MT_WB, 0));
      pending_reqs.push_back(mk(0, 64'hc0000, 64'h1000, mrat_pkg::MT_RESERVED, 0)); // unknown
      pending_reqs.push_back(mk(0, 64'hc0000, 64'h1000, mrat_pkg::MT_WC, 1));
      pending_reqs.push_back(mk(0, 64'h123, 64'h1000, mrat_pkg::MT_UC, 0));     // misaligned
      pending_reqs.push_back(mk(0, 0, 64'h800, mrat_pkg::MT_UC, 0));            // too short
      pending_reqs.push_back(mk(0, 0, 64'h3000, mrat_pkg::MT_UC, 0));           // not pow2
      pending_reqs.push_back(mk(0, 64'h2000, 64'h4000, mrat_pkg::MT_UC, 0));    // base vs length
      pending_reqs.push_back(mk(0, 0, 64'h100000, mrat_pkg::MT_WT, 0));
      pending_reqs.push_back(mk(0, 64'h100000, 64'h100000, mrat_pkg::MT_WB, 0));
      pending_reqs.push_back(mk(0, 64'h100000, 64'h100000, mrat_pkg::MT_WP, 0)); // takeover
      pending_reqs.push_back(mk(0, 0, 64'h200000, mrat_pkg::MT_UC, 0));         // UC over WP conflict
      pending_reqs.push_back(mk(0, 0, 64'h400000, mrat_pkg::MT_WC, 0));         // conflict
      pending_reqs.push_back(mk(1, 64'h80000, 64'h4000, mrat_pkg::MT_UC, 0));   // fixed remove
      pending_reqs.push_back(mk(1, 64'h100000, 64'h100000, mrat_pkg::MT_UC, 0));
      pending_reqs.push_back(mk(1, 64'h100000, 64'h100000, mrat_pkg::MT_UC, 0)); // not found
      pending_reqs.push_back(mk(1, 0, 64'd1 << 36, mrat_pkg::MT_UC, 0));        // inactive match
      pending_reqs.push_back(mk(0, 64'h8_0000_0000_0000, 64'h8_0000_0000_0000,
                                mrat_pkg::MT_WB, 0));
      pending_reqs.push_back(mk(0, 0, 64'h10_0000_0000_0000, mrat_pkg::MT_UC, 0));
      pending_reqs.push_back(mk(1, 64'hf_ffff_ffff_ffff, 64'h1f_ffff_ffff_ffff,
                                mrat_pkg::MT_RESERVED, 1));
      for (int i = 0; i < 9; i++)
         pending_reqs.push_back(mk(0, 64'(i + 1) << 24, 64'h1000000,
                                   mrat_pkg::MT_UC, 0)); // fill up
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(mrat_pkg::CSR_PA_BITS, 6'd52);
               write_reg(mrat_pkg::CSR_VAR_COUNT, 6'd1);
            end
            1: begin
               write_reg(mrat_pkg::CSR_FIXED_ENABLE, 6'd0);
               write_reg(mrat_pkg::CSR_VAR_COUNT, 6'd0);
               write_reg(mrat_pkg::CSR_PA_BITS, 6'd0);
            end
            2: begin
               write_reg(mrat_pkg::CSR_VAR_COUNT, 6'd15);
               write_reg(mrat_pkg::CSR_PA_BITS, 6'd63);
            end
            3: begin
               write_reg(mrat_pkg::CSR_FIXED_ENABLE, 6'd1);
               write_reg(mrat_pkg::CSR_VAR_COUNT, 6'd8);
               write_reg(mrat_pkg::CSR_PA_BITS, 6'd36);
            end
            4: begin
               write_reg(mrat_pkg::CSR_VAR_COUNT, 6'($urandom_range(0, 15)));
               write_reg(mrat_pkg::CSR_PA_BITS, 6'($urandom_range(30, 55)));
            end
            default: begin
               write_reg(mrat_pkg::CSR_FIXED_ENABLE, 6'($urandom_range(0, 1)));
               write_reg(mrat_pkg::CSR_VAR_COUNT, 6'd3);
            end
         endcase
         for (int k = 0; k < 125; k++) pending_reqs.push_back(rand_req());
         drain();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* memory_range_attribute_table_top.f */
+incdir+hw/rtl
hw/rtl/mrat_pkg.sv
hw/rtl/mrat_ram.sv
hw/rtl/memory_range_attribute_table_top.sv
sim/tb_memory_range_attribute_table_top.sv
